FILE: sv/tags_pkg.sv
// ---------------------------------------------------------------------------
// tags_pkg
// Shared types and constants of the time-aware gate scheduler.
// ---------------------------------------------------------------------------
package tags_pkg;

   // Queue geometry
   localparam int NUM_PRIORITIES = 16;
   localparam int QUEUE_DEPTH    = 256;
   localparam int PRI_W          = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
   localparam int HEAD_W         = $clog2(QUEUE_DEPTH);
   localparam int CNT_W          = $clog2(QUEUE_DEPTH + 1);
   localparam int STORE_DEPTH    = NUM_PRIORITIES * QUEUE_DEPTH;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int TIME_W         = 64;
   localparam int TOTAL_W        = 13;
   localparam logic [TOTAL_W-1:0] TOTAL_CAP = 13'd8191;

   // Register indexes
   typedef enum logic [2:0] {
      REG_EPOCH      = 3'd0,
      REG_CYCLE_TIME = 3'd1,
      REG_SLOT0_DUR  = 3'd2,
      REG_SLOT0_MASK = 3'd3,
      REG_SLOT1_DUR  = 3'd4,
      REG_SLOT1_MASK = 3'd5,
      REG_ACTIVE     = 3'd6,
      REG_LIMIT      = 3'd7
   } reg_index_type;

   // Operations
   typedef enum logic [1:0] {
      OP_ENQ   = 2'd0,
      OP_DEQ   = 2'd1,
      OP_FLUSH = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   // Result codes
   localparam logic [2:0] ST_ENQ   = 3'd0;
   localparam logic [2:0] ST_DROP  = 3'd1;
   localparam logic [2:0] ST_SENT  = 3'd2;
   localparam logic [2:0] ST_IDLE  = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;
   localparam logic [2:0] ST_FLUSH = 3'd5;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [3:0]        priority_req;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [3:0]         sent_priority;
      logic [TIME_W-1:0]  latency;
      logic [TIME_W-1:0]  wake_time;
      logic [TOTAL_W-1:0] queued_total;
   } rsp_type;

endpackage

FILE: sv/tags_ram.sv
// ---------------------------------------------------------------------------
// tags_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tags_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tags_mod.sv
// ---------------------------------------------------------------------------
// tags_mod
// Bit-serial restoring modulo: one dividend bit per cycle.
// ---------------------------------------------------------------------------
module tags_mod import tags_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [TIME_W-1:0] dividend,
   input  logic [TIME_W-1:0] divisor,
   output logic              done,
   output logic [TIME_W-1:0] remainder
);

   localparam int STEP_W = $clog2(TIME_W);

   logic [TIME_W-1:0] shift_ff;
   logic [TIME_W-1:0] rem_ff;
   logic [STEP_W-1:0] step_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   rem_in;

   // one trial subtraction per cycle
   always_comb begin
      trial  = {rem_ff, shift_ff[TIME_W-1]};
      rem_in = trial;
      if (trial >= {1'b0, divisor}) begin
         rem_in = trial - {1'b0, divisor};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            step_ff  <= '0;
            shift_ff <= dividend;
            rem_ff   <= '0;
         end else if (busy_ff) begin
            shift_ff <= {shift_ff[TIME_W-2:0], 1'b0};
            rem_ff   <= rem_in[TIME_W-1:0];
            step_ff  <= step_ff + 1'b1;
            if (step_ff == STEP_W'(TIME_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

FILE: sv/time_aware_gate_scheduler.sv
// ---------------------------------------------------------------------------
// time_aware_gate_scheduler
// Per-priority timestamp FIFOs behind a two-slot gate control list.
// ---------------------------------------------------------------------------
// Enqueue, flush and unknown operations pass from accept through S_DONE to the
// output register. For a dequeue with packets held and a nonzero cycle, the
// offset in the gate cycle comes from a bit-serial modulo unit that retires
// one bit of (now - epoch) per cycle, followed by a two-step slot walk, a
// priority pick and a timestamp RAM read or a three-step wake time
// computation. One item is in work at a time; a finished result waits in
// the output register while the next item is accepted.
// ---------------------------------------------------------------------------
module time_aware_gate_scheduler import tags_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [2:0]    csr_index,
   input  logic [63:0]   csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_START, S_MOD, S_SLOT0, S_SLOT1, S_PICK, S_READ,
      S_WAKE1, S_WAKE2, S_DONE
   } state_type;

   state_type state_ff;

   // configuration
   logic [TIME_W-1:0]  base_ff, cycle_ff, dur0_ff, dur1_ff;
   logic [15:0]        mask0_ff, mask1_ff;
   logic [1:0]         active_ff;
   logic [TOTAL_W-1:0] limit_ff;

   // queue bookkeeping
   logic [HEAD_W-1:0]  head_ff [NUM_PRIORITIES];
   logic [CNT_W-1:0]   cnt_ff  [NUM_PRIORITIES];
   logic [TOTAL_W-1:0] total_ff;

   // working registers
   logic [TIME_W-1:0]  now_ff, diff_ff, off_ff, end_ff, send_ff, wake_ff;
   logic [15:0]        mask_ff;
   logic [PRI_W-1:0]   q_ff;
   logic [2:0]         res_status_ff;
   logic [TIME_W-1:0]  res_lat_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               accept;
   logic [PRI_W-1:0]   pri;
   logic               drop;
   logic [CNT_W:0]     slot_sum;
   logic [HEAD_W-1:0]  slot;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [NUM_PRIORITIES-1:0] ready_vec;
   logic               pick_any;
   logic [PRI_W-1:0]   pick_q;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [TIME_W-1:0]  rd_data;
   logic               mod_start;
   logic               mod_done;
   logic [TIME_W-1:0]  mod_rem;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign pri       = PRI_W'(req_data.priority_req & 4'(NUM_PRIORITIES - 1));

   // enqueue admission and tail slot
   always_comb begin
      drop = (total_ff >= limit_ff) || (total_ff >= TOTAL_CAP) ||
             (cnt_ff[pri] >= CNT_W'(QUEUE_DEPTH));
      slot_sum = (CNT_W+1)'(head_ff[pri]) + (CNT_W+1)'(cnt_ff[pri]);
      if (slot_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
         slot_sum = slot_sum - (CNT_W+1)'(QUEUE_DEPTH);
      end
      slot    = slot_sum[HEAD_W-1:0];
      wr_en   = accept && (req_data.opcode == OP_ENQ) && !drop;
      wr_addr = ADDR_W'(pri) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(slot);
   end

   // highest open, non-empty priority
   always_comb begin
      pick_any = 1'b0;
      pick_q   = '0;
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
         ready_vec[p] = mask_ff[p] && (cnt_ff[p] != '0);
      end
      for (int p = 0; p < NUM_PRIORITIES; p++) begin
         if (ready_vec[p]) begin
            pick_any = 1'b1;
            pick_q   = PRI_W'(p);
         end
      end
      rd_en   = (state_ff == S_PICK) && pick_any;
      rd_addr = ADDR_W'(pick_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_ff[pick_q]);
   end

   assign mod_start = (state_ff == S_START);

   tags_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (diff_ff),
      .divisor   (cycle_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   tags_ram #(.WIDTH(TIME_W), .DEPTH(STORE_DEPTH)) u_stamps (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.now),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer, queue state, configuration and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         cycle_ff     <= 64'd1000000;
         dur0_ff      <= 64'd10000;
         mask0_ff     <= 16'h8001;
         dur1_ff      <= 64'd990000;
         mask1_ff     <= 16'h0001;
         active_ff    <= 2'd2;
         limit_ff     <= 13'd4096;
         total_ff     <= '0;
         for (int p = 0; p < NUM_PRIORITIES; p++) begin
            head_ff[p] <= '0;
            cnt_ff[p]  <= '0;
         end
      end else begin
         // configuration writes
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_EPOCH:      base_ff   <= csr_data;
               REG_CYCLE_TIME: cycle_ff  <= csr_data;
               REG_SLOT0_DUR:  dur0_ff   <= csr_data;
               REG_SLOT0_MASK: mask0_ff  <= csr_data[15:0];
               REG_SLOT1_DUR:  dur1_ff   <= csr_data;
               REG_SLOT1_MASK: mask1_ff  <= csr_data[15:0];
               REG_ACTIVE:     active_ff <= csr_data[1:0];
               REG_LIMIT:      limit_ff  <= csr_data[TOTAL_W-1:0];
               default: ;
            endcase
         end

         // result taken and nothing new loaded this cycle
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  now_ff        <= req_data.now;
                  q_ff          <= '0;
                  res_lat_ff    <= '0;
                  wake_ff       <= '0;
                  res_status_ff <= ST_IDLE;
                  state_ff      <= S_DONE;
                  case (opcode_type'(req_data.opcode))
                     OP_ENQ: begin
                        if (drop) begin
                           res_status_ff <= ST_DROP;
                        end else begin
                           cnt_ff[pri]   <= cnt_ff[pri] + 1'b1;
                           total_ff      <= total_ff + 1'b1;
                           res_status_ff <= ST_ENQ;
                        end
                     end
                     OP_DEQ: begin
                        if (total_ff != '0 && cycle_ff != '0) begin
                           diff_ff  <= req_data.now - base_ff;
                           state_ff <= S_START;
                        end
                     end
                     OP_FLUSH: begin
                        for (int p = 0; p < NUM_PRIORITIES; p++) begin
                           head_ff[p] <= '0;
                           cnt_ff[p]  <= '0;
                        end
                        total_ff      <= '0;
                        res_status_ff <= ST_FLUSH;
                     end
                     default: ;
                  endcase
               end
            end
            S_START: begin
               state_ff <= S_MOD;
            end
            S_MOD: begin
               if (mod_done) begin
                  off_ff   <= mod_rem;
                  end_ff   <= dur0_ff;
                  state_ff <= S_SLOT0;
               end
            end
            // first slot of the gate list
            S_SLOT0: begin
               if (active_ff == 2'd0) begin
                  mask_ff  <= '0;
                  send_ff  <= '0;
                  state_ff <= S_PICK;
               end else if (off_ff < end_ff) begin
                  mask_ff  <= mask0_ff;
                  send_ff  <= end_ff;
                  state_ff <= S_PICK;
               end else begin
                  end_ff   <= end_ff + dur1_ff;
                  state_ff <= S_SLOT1;
               end
            end
            // second slot, if walked
            S_SLOT1: begin
               if (active_ff >= 2'd2 && off_ff < end_ff) begin
                  mask_ff <= mask1_ff;
                  send_ff <= end_ff;
               end else begin
                  mask_ff <= '0;
                  send_ff <= '0;
               end
               state_ff <= S_PICK;
            end
            S_PICK: begin
               if (pick_any) begin
                  q_ff <= pick_q;
                  if (head_ff[pick_q] == HEAD_W'(QUEUE_DEPTH - 1)) begin
                     head_ff[pick_q] <= '0;
                  end else begin
                     head_ff[pick_q] <= head_ff[pick_q] + 1'b1;
                  end
                  cnt_ff[pick_q] <= cnt_ff[pick_q] - 1'b1;
                  total_ff       <= total_ff - 1'b1;
                  state_ff       <= S_READ;
               end else begin
                  wake_ff  <= now_ff - off_ff;
                  state_ff <= S_WAKE1;
               end
            end
            S_READ: begin
               res_lat_ff    <= now_ff - rd_data;
               res_status_ff <= ST_SENT;
               state_ff      <= S_DONE;
            end
            S_WAKE1: begin
               wake_ff  <= wake_ff + send_ff;
               state_ff <= S_WAKE2;
            end
            S_WAKE2: begin
               if (wake_ff <= now_ff) begin
                  wake_ff <= wake_ff + cycle_ff;
               end
               res_status_ff <= ST_WAIT;
               state_ff      <= S_DONE;
            end
            // hand result to the output register
            S_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff              <= 1'b1;
                  rsp_data_ff.status        <= res_status_ff;
                  rsp_data_ff.sent_priority <= 4'(q_ff);
                  rsp_data_ff.latency       <= res_lat_ff;
                  rsp_data_ff.wake_time     <= wake_ff;
                  rsp_data_ff.queued_total  <= total_ff;
                  state_ff                  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the time-aware gate scheduler.
// ---------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the per-priority timestamp FIFOs
// and the gate list registers. It predicts the result of every accepted item,
// and each result is compared field by field in arrival order. Directed items
// cover the corner cases. Random phases under several gate list settings
// follow, with random idle bursts on both channels.
// ---------------------------------------------------------------------------
module tb_top;
   import tags_pkg::*;

   // Scoreboard: gate scheduler predictor plus expected result queue
   class sched_scoreboard;
      logic [63:0] base_ns, cycle_ns;
      logic [63:0] slot_dur [2];
      logic [15:0] slot_gate [2];
      logic [1:0]  slots_walked;
      logic [12:0] pkt_limit;
      logic [63:0] stamps [NUM_PRIORITIES][QUEUE_DEPTH];
      int          head [NUM_PRIORITIES];
      int          depth [NUM_PRIORITIES];
      int          held;
      rsp_type     awaited [$];
      int          errors;

      function new();
         base_ns      = 64'd0;
         cycle_ns     = 64'd1000000;
         slot_dur[0]  = 64'd10000;
         slot_gate[0] = 16'h8001;
         slot_dur[1]  = 64'd990000;
         slot_gate[1] = 16'h0001;
         slots_walked = 2'd2;
         pkt_limit    = 13'd4096;
         held         = 0;
         errors       = 0;
         for (int i = 0; i < NUM_PRIORITIES; i++) begin
            head[i]  = 0;
            depth[i] = 0;
         end
      endfunction

      function void write_reg(reg_index_type idx, logic [63:0] v);
         case (idx)
            REG_EPOCH:      base_ns      = v;
            REG_CYCLE_TIME: cycle_ns     = v;
            REG_SLOT0_DUR:  slot_dur[0]  = v;
            REG_SLOT0_MASK: slot_gate[0] = v[15:0];
            REG_SLOT1_DUR:  slot_dur[1]  = v;
            REG_SLOT1_MASK: slot_gate[1] = v[15:0];
            REG_ACTIVE:     slots_walked = v[1:0];
            REG_LIMIT:      pkt_limit    = v[12:0];
            default: ;
         endcase
      endfunction

      // Advance the model by one item and return its result
      function rsp_type gate_step(req_type r);
         rsp_type     o;
         int          p, walk;
         logic [63:0] off, acc, fin, open_mask, slot_end, nxt;
         bit          popped;
         o = '0;
         o.status = ST_IDLE;
         p = r.priority_req;
         case (r.opcode)
            OP_ENQ: begin
               if (held >= pkt_limit || held >= TOTAL_CAP || depth[p] >= QUEUE_DEPTH) begin
                  o.status = ST_DROP;
               end else begin
                  stamps[p][(head[p] + depth[p]) % QUEUE_DEPTH] = r.now;
                  depth[p]++;
                  held++;
                  o.status = ST_ENQ;
               end
            end
            OP_DEQ: begin
               if (held != 0 && cycle_ns != 0) begin
                  off = (r.now - base_ns) % cycle_ns;
                  acc = 0;
                  open_mask = 0;
                  slot_end = 0;
                  popped = 0;
                  walk = (slots_walked > 2) ? 2 : slots_walked;
                  for (int s = 0; s < walk; s++) begin
                     fin = acc + slot_dur[s];
                     if (off < fin) begin
                        open_mask = slot_gate[s];
                        slot_end = fin;
                        break;
                     end
                     acc = fin;
                  end
                  for (int q = NUM_PRIORITIES - 1; q >= 0; q--) begin
                     if (open_mask[q] && depth[q] > 0) begin
                        o.latency = r.now - stamps[q][head[q]];
                        head[q] = (head[q] + 1) % QUEUE_DEPTH;
                        depth[q]--;
                        held--;
                        o.status = ST_SENT;
                        o.sent_priority = q;
                        popped = 1;
                        break;
                     end
                  end
                  if (!popped) begin
                     nxt = (r.now - off) + slot_end;
                     if (nxt <= r.now) nxt = nxt + cycle_ns;
                     o.status = ST_WAIT;
                     o.wake_time = nxt;
                  end
               end
            end
            OP_FLUSH: begin
               for (int i = 0; i < NUM_PRIORITIES; i++) begin
                  head[i]  = 0;
                  depth[i] = 0;
               end
               held = 0;
               o.status = ST_FLUSH;
            end
            default: ;
         endcase
         o.queued_total = held;
         return o;
      endfunction

      function void note_item(req_type r);
         awaited.push_back(gate_step(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (awaited.size() == 0) begin
            $error("result with nothing expected: %p", got);
            errors++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.sent_priority !== want.sent_priority) begin
            $error("sent_priority: expected %0d, got %0d", want.sent_priority,
                   got.sent_priority);
            errors++;
         end
         if (got.latency !== want.latency) begin
            $error("latency: expected %0h, got %0h", want.latency, got.latency);
            errors++;
         end
         if (got.wake_time !== want.wake_time) begin
            $error("wake_time: expected %0h, got %0h", want.wake_time, got.wake_time);
            errors++;
         end
         if (got.queued_total !== want.queued_total) begin
            $error("queued_total: expected %0d, got %0d", want.queued_total,
                   got.queued_total);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   sched_scoreboard sb = new();
   bit          quiet = 0;     // no idling at all
   bit          calm = 0;      // stretch without idling within a phase
   int          stuck_cycles = 0;
   logic [63:0] clock_ns = 64'd0;

   time_aware_gate_scheduler uut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Result side: check accepted items, stall in random bursts
   initial begin
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
         if (burst > 0) begin
            burst--;
            rsp_stall <= 1'b1;
         end else if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
            burst = $urandom_range(1, 11) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: cycles in which no item, result or register write is accepted
   initial begin
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready) || reset)
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= 5000) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic send_item(logic [1:0] op, logic [3:0] pri, logic [63:0] t);
      req_type r;
      r.opcode = op;
      r.priority_req = pri;
      r.now = t;
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      sb.note_item(r);
      if (!quiet && !calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic write_csr(reg_index_type idx, logic [63:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, v);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Let the block drain before touching its registers
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Pick one of a few extreme values, a random one or the typical value
   function automatic logic [63:0] pick64(logic [63:0] typical);
      case ($urandom_range(0, 4))
         0: return 64'd0;
         1: return '1;
         2: return rand64();
         default: return typical;
      endcase
   endfunction

   task automatic program_gates(int k);
      logic [63:0] cyc, d0;
      cyc = (k == 1) ? 64'd0 : (k == 2) ? '1 : 64'd500 + $urandom_range(0, 20000);
      d0 = $urandom_range(0, cyc > 64'd20000 ? 20000 : cyc);
      write_csr(REG_EPOCH, (k == 2) ? '1 : pick64($urandom_range(0, 5000)));
      write_csr(REG_CYCLE_TIME, cyc);
      write_csr(REG_SLOT0_DUR, (k == 3) ? '1 : pick64(d0));
      write_csr(REG_SLOT0_MASK, (k == 4) ? 64'hFFFF : (k == 5) ? 64'd0 : $urandom);
      write_csr(REG_SLOT1_DUR, (k == 3) ? '1 : pick64(cyc - d0));
      write_csr(REG_SLOT1_MASK, (k == 5) ? 64'hFFFF : $urandom);
      write_csr(REG_ACTIVE, k % 3);
      write_csr(REG_LIMIT, (k == 6) ? 64'd0 : (k == 7) ? 64'd5 : (k == 0) ? 64'd4096
                : $urandom_range(1, 4096));
   endtask

   // Random traffic; fixed_pri >= 0 biases enqueues to one priority
   task automatic run_traffic(int items, int enq_pct, int fixed_pri);
      int          roll;
      logic [1:0]  op;
      logic [3:0]  pri;
      logic [63:0] t;
      for (int i = 0; i < items; i++) begin
         if (i % 100 == 0) calm = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < enq_pct) op = OP_ENQ;
         else if (roll < 95) op = OP_DEQ;
         else if (roll < 98) op = OP_FLUSH;
         else op = OP_NONE;
         pri = (fixed_pri >= 0 && $urandom_range(0, 9) != 0) ? fixed_pri : $urandom;
         clock_ns = clock_ns + $urandom_range(0, 4000);
         t = ($urandom_range(0, 15) == 0) ? rand64() : clock_ns;
         send_item(op, pri, t);
      end
      calm = 0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners under reset settings
      send_item(OP_DEQ, 4'd0, 64'd5);                  // empty block
      send_item(OP_ENQ, 4'd0, 64'd0);
      send_item(OP_ENQ, 4'd15, '1);
      send_item(OP_ENQ, 4'd7, 64'd100);
      send_item(OP_DEQ, 4'd0, 64'd20);                 // slot 0, pri 15 open
      send_item(OP_DEQ, 4'd0, 64'd30);                 // slot 0, pri 0 open
      send_item(OP_DEQ, 4'd0, 64'd500000);             // slot 1, only pri 7 held
      send_item(OP_DEQ, 4'd0, 64'hFFFF_FFFF_FFFF_FFF0); // wake time wraps
      send_item(OP_NONE, 4'd9, '1);                     // unknown op
      send_item(OP_FLUSH, 4'd0, 64'd0);
      send_item(OP_DEQ, 4'd0, 64'd0);
      send_item(OP_ENQ, 4'd10, 64'h5555_5555_5555_5555);
      send_item(OP_ENQ, 4'd5, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(OP_DEQ, 4'd3, 64'd999999);
      send_item(OP_FLUSH, 4'd0, 64'd0);

      // Random phases under a range of gate lists
      run_traffic(100, 50, -1);
      for (int k = 0; k < 9; k++) begin
         wait_idle();
         program_gates(k);
         run_traffic(130, (k == 4) ? 70 : 50, -1);
      end

      // Fill one FIFO past its depth, then drain it
      wait_idle();
      program_gates(0);
      write_csr(REG_SLOT0_MASK, 64'hFFFF);
      write_csr(REG_SLOT1_MASK, 64'hFFFF);
      run_traffic(300, 97, $urandom_range(0, 15));
      run_traffic(100, 20, -1);

      // Last part without idling
      wait_idle();
      program_gates(4);
      quiet = 1;
      run_traffic(170, 50, -1);

      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
